@@ rtl/core/mfpr_pkg.sv @@
// ----------------------------------------------------------------------------
// mfpr_pkg
// Shared widths and constants for the microphone frame peak/RMS meter.
// ----------------------------------------------------------------------------
package mfpr_pkg;

    localparam int RAW_W  = 32;
    localparam int PCM_W  = 16;
    localparam int MAG_W  = 16;
    localparam int PEAK_W = 15;
    localparam int RMS_W  = 16;

    // Mean square never exceeds 32768^2, so 31 bits hold it.
    localparam int MEAN_W = 2 * MAG_W - 1;
    // Square-root steps: one per bit pair of the mean.
    localparam int SQRT_STEPS = (MEAN_W + 1) / 2;

    localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

    localparam int MAX_FRAME_DEFAULT   = 1024;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

endpackage

@@ rtl/core/mfpr_queue.sv @@
// ----------------------------------------------------------------------------
// mfpr_queue
// Small register FIFO between the accumulating front end and the back end.
// ----------------------------------------------------------------------------
module mfpr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mfpr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/core/mfpr_front.sv @@
// ----------------------------------------------------------------------------
// mfpr_front
// Accepts raw words, derives the PCM sample, keeps peak, square sum and
// count for the frame, and queues one entry per word.
// ----------------------------------------------------------------------------
module mfpr_front #(
    parameter int MAX_FRAME = mfpr_pkg::MAX_FRAME_DEFAULT,
    parameter int CNT_W     = $clog2(MAX_FRAME + 1),
    parameter int SUM_W     = 2 * mfpr_pkg::MAG_W - 2 + CNT_W,
    parameter int ENTRY_W   = mfpr_pkg::PCM_W + 2 + mfpr_pkg::PEAK_W + CNT_W + SUM_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [mfpr_pkg::RAW_W-1:0]  raw_word,
    input  logic                               last_of_frame,
    input  logic                               q_full,
    output logic                               q_push,
    output logic [ENTRY_W-1:0]                 q_data
);

    logic                          fwd_en_reg;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [mfpr_pkg::PEAK_W-1:0]   peak_reg, peak_next;

    logic [mfpr_pkg::PCM_W-1:0]    top;
    logic [mfpr_pkg::MAG_W-1:0]    mag;
    logic [mfpr_pkg::PEAK_W-1:0]   mag_sat;
    logic [2*mfpr_pkg::MAG_W-1:0]  square;
    logic                          room;
    logic [SUM_W-1:0]              sum_upd;
    logic [CNT_W-1:0]              count_upd;
    logic [mfpr_pkg::PEAK_W-1:0]   peak_upd;
    logic                          accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    assign top     = raw_word[mfpr_pkg::RAW_W-1 -: mfpr_pkg::PCM_W];
    // Two's complement negate; -32768 gives 32768 as an unsigned magnitude.
    assign mag     = top[mfpr_pkg::PCM_W-1] ? (~top + 1'b1) : top;
    assign mag_sat = mag[mfpr_pkg::MAG_W-1] ? mfpr_pkg::PEAK_MAX
                                            : mag[mfpr_pkg::PEAK_W-1:0];
    assign square  = mag * mag;

    // Past MAX_FRAME samples, hold sum and count and keep tracking the peak.
    assign room      = (count_reg < CNT_W'(MAX_FRAME));
    assign sum_upd   = room ? (sum_reg + SUM_W'(square)) : sum_reg;
    assign count_upd = room ? (count_reg + 1'b1) : count_reg;
    assign peak_upd  = (mag_sat > peak_reg) ? mag_sat : peak_reg;

    assign q_data = {top, fwd_en_reg, last_of_frame, peak_upd, count_upd, sum_upd};

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        peak_next  = peak_reg;
        if (accept)
        begin
            if (last_of_frame)
            begin
                sum_next   = '0;
                count_next = '0;
                peak_next  = '0;
            end
            else
            begin
                sum_next   = sum_upd;
                count_next = count_upd;
                peak_next  = peak_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_en_reg <= 1'b0;
            sum_reg    <= '0;
            count_reg  <= '0;
            peak_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fwd_en_reg <= cfg_wr_data;
            end
            sum_reg   <= sum_next;
            count_reg <= count_next;
            peak_reg  <= peak_next;
        end
    end

endmodule

@@ rtl/core/mfpr_back.sv @@
// ----------------------------------------------------------------------------
// mfpr_back
// Drains the queue into the output register. A frame-end entry first runs
// a restoring divide (one quotient bit per cycle) and a digit-by-digit
// square root (one bit pair per cycle).
// ----------------------------------------------------------------------------
module mfpr_back #(
    parameter int MAX_FRAME = mfpr_pkg::MAX_FRAME_DEFAULT,
    parameter int CNT_W     = $clog2(MAX_FRAME + 1),
    parameter int SUM_W     = 2 * mfpr_pkg::MAG_W - 2 + CNT_W,
    parameter int ENTRY_W   = mfpr_pkg::PCM_W + 2 + mfpr_pkg::PEAK_W + CNT_W + SUM_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ENTRY_W-1:0]                  q_data,
    input  logic                                q_empty,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mfpr_pkg::PCM_W-1:0]   pcm_sample,
    output logic                                pcm_valid,
    output logic                                metrics_valid,
    output logic [mfpr_pkg::RMS_W-1:0]          rms_level,
    output logic [mfpr_pkg::PEAK_W-1:0]         peak_level
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam int ROOT_W = mfpr_pkg::MEAN_W + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SQRT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // Unpacked queue entry
    logic [mfpr_pkg::PCM_W-1:0]   e_pcm;
    logic                         e_fwd;
    logic                         e_last;
    logic [mfpr_pkg::PEAK_W-1:0]  e_peak;
    logic [CNT_W-1:0]             e_count;
    logic [SUM_W-1:0]             e_sum;

    logic [1:0]                   state_reg, state_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic [SUM_W-1:0]             quo_reg, quo_next;
    logic [CNT_W-1:0]             rem_reg, rem_next;
    logic [CNT_W-1:0]             div_reg, div_next;
    logic [mfpr_pkg::MEAN_W-1:0]  val_reg, val_next;
    logic [ROOT_W-1:0]            root_reg, root_next;
    logic [mfpr_pkg::PCM_W-1:0]   hold_pcm_reg, hold_pcm_next;
    logic                         hold_fwd_reg, hold_fwd_next;
    logic [mfpr_pkg::PEAK_W-1:0]  hold_peak_reg, hold_peak_next;

    logic                         out_valid_reg, out_valid_next;
    logic [mfpr_pkg::PCM_W-1:0]   pcm_reg, pcm_next;
    logic                         pcmv_reg, pcmv_next;
    logic                         metv_reg, metv_next;
    logic [mfpr_pkg::RMS_W-1:0]   rms_reg, rms_next;
    logic [mfpr_pkg::PEAK_W-1:0]  peak_reg, peak_next;

    logic                         slot_free;
    logic [CNT_W:0]               rem_sh;
    logic                         div_ge;
    logic [ROOT_W-1:0]            bit_val;
    logic [ROOT_W-1:0]            trial;
    logic                         sqrt_ge;

    assign {e_pcm, e_fwd, e_last, e_peak, e_count, e_sum} = q_data;

    assign slot_free = !out_valid_reg || !out_stall;
    assign q_pop     = !q_empty && (state_reg == S_IDLE) && (e_last || slot_free);

    // Divide step: remainder stays below the divisor, so CNT_W+1 bits suffice.
    assign rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge = (rem_sh >= {1'b0, div_reg});

    // Root step
    assign bit_val = ROOT_W'(1) << {step_reg, 1'b0};
    assign trial   = root_reg + bit_val;
    assign sqrt_ge = ({1'b0, val_reg} >= trial);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        val_next       = val_reg;
        root_next      = root_reg;
        hold_pcm_next  = hold_pcm_reg;
        hold_fwd_next  = hold_fwd_reg;
        hold_peak_next = hold_peak_reg;

        out_valid_next = out_valid_reg && out_stall;
        pcm_next       = pcm_reg;
        pcmv_next      = pcmv_reg;
        metv_next      = metv_reg;
        rms_next       = rms_reg;
        peak_next      = peak_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    if (e_last)
                    begin
                        hold_pcm_next  = e_pcm;
                        hold_fwd_next  = e_fwd;
                        hold_peak_next = e_peak;
                        quo_next       = e_sum;
                        rem_next       = '0;
                        div_next       = e_count;
                        step_next      = STEP_W'(SUM_W - 1);
                        state_next     = S_DIV;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        pcm_next       = e_pcm;
                        pcmv_next      = e_fwd;
                        metv_next      = 1'b0;
                        rms_next       = '0;
                        peak_next      = '0;
                    end
                end
            end
            S_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = CNT_W'(rem_sh - {1'b0, div_reg});
                end
                else
                begin
                    rem_next = rem_sh[CNT_W-1:0];
                end
                quo_next = {quo_reg[SUM_W-2:0], div_ge};
                if (step_reg == '0)
                begin
                    // Empty count cannot occur at frame end; force a zero mean anyway.
                    val_next   = (div_reg == '0) ? '0
                                 : {quo_reg[mfpr_pkg::MEAN_W-2:0], div_ge};
                    root_next  = '0;
                    step_next  = STEP_W'(mfpr_pkg::SQRT_STEPS - 1);
                    state_next = S_SQRT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_SQRT:
            begin
                if (sqrt_ge)
                begin
                    val_next  = mfpr_pkg::MEAN_W'({1'b0, val_reg} - trial);
                    root_next = (root_reg >> 1) + bit_val;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                if (step_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    pcm_next       = hold_pcm_reg;
                    pcmv_next      = hold_fwd_reg;
                    metv_next      = 1'b1;
                    rms_next       = root_reg[mfpr_pkg::RMS_W-1:0];
                    peak_next      = hold_peak_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        val_reg       <= val_next;
        root_reg      <= root_next;
        hold_pcm_reg  <= hold_pcm_next;
        hold_fwd_reg  <= hold_fwd_next;
        hold_peak_reg <= hold_peak_next;
        pcm_reg       <= pcm_next;
        pcmv_reg      <= pcmv_next;
        metv_reg      <= metv_next;
        rms_reg       <= rms_next;
        peak_reg      <= peak_next;
    end

    assign out_valid     = out_valid_reg;
    assign pcm_sample    = pcm_reg;
    assign pcm_valid     = pcmv_reg;
    assign metrics_valid = metv_reg;
    assign rms_level     = rms_reg;
    assign peak_level    = peak_reg;

endmodule

@@ rtl/core/mic_frame_peak_rms_meter.sv @@
// ----------------------------------------------------------------------------
// mic_frame_peak_rms_meter
// Frame peak and RMS level meter for 32-bit left-justified microphone words.
// ----------------------------------------------------------------------------
// Every accepted word yields one result item carrying the 16-bit PCM sample
// taken from the top of the word; the item for the word flagged
// last_of_frame also carries the frame peak and RMS level. The front end
// takes one word per cycle while the queue has room and accumulates into
// the frame state in that cycle. A QUEUE_DEPTH-entry queue feeds the back
// end, which forwards ordinary words at one per cycle while its output is
// not stalled. A frame's final word is loaded, its sum divided by the count
// at one quotient bit per cycle, square-rooted and output; no new entry is
// popped meanwhile. Once the queue has filled the input is paced by the back
// end; input stall rises only when the queue fills.
// Only the first MAX_FRAME samples of a frame enter the RMS; the peak covers
// the whole frame.
// ----------------------------------------------------------------------------
module mic_frame_peak_rms_meter #(
    parameter int MAX_FRAME   = mfpr_pkg::MAX_FRAME_DEFAULT,
    parameter int QUEUE_DEPTH = mfpr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [mfpr_pkg::RAW_W-1:0]  raw_word,
    input  logic                               last_of_frame,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [mfpr_pkg::PCM_W-1:0]  pcm_sample,
    output logic                               pcm_valid,
    output logic                               metrics_valid,
    output logic [mfpr_pkg::RMS_W-1:0]         rms_level,
    output logic [mfpr_pkg::PEAK_W-1:0]        peak_level
);

    localparam int CNT_W   = $clog2(MAX_FRAME + 1);
    localparam int SUM_W   = 2 * mfpr_pkg::MAG_W - 2 + CNT_W;
    localparam int ENTRY_W = mfpr_pkg::PCM_W + 2 + mfpr_pkg::PEAK_W + CNT_W + SUM_W;

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_wr_data;
    logic [ENTRY_W-1:0] q_rd_data;

    mfpr_front #(
        .MAX_FRAME (MAX_FRAME),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W),
        .ENTRY_W   (ENTRY_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .raw_word      (raw_word),
        .last_of_frame (last_of_frame),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wr_data)
    );

    mfpr_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    mfpr_back #(
        .MAX_FRAME (MAX_FRAME),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_rd_data),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pcm_sample    (pcm_sample),
        .pcm_valid     (pcm_valid),
        .metrics_valid (metrics_valid),
        .rms_level     (rms_level),
        .peak_level    (peak_level)
    );

endmodule

@@ rtl/core/mfpr_checker.sv @@
// ----------------------------------------------------------------------------
// mfpr_checker
// Port-level checks for the meter, bound to the top level.
// ----------------------------------------------------------------------------
module mfpr_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [mfpr_pkg::PCM_W-1:0]  pcm_sample,
    input logic                               pcm_valid,
    input logic                               metrics_valid,
    input logic [mfpr_pkg::RMS_W-1:0]         rms_level,
    input logic [mfpr_pkg::PEAK_W-1:0]        peak_level
);

    // Hold a stalled result item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pcm_sample)
            && $stable(pcm_valid) && $stable(metrics_valid)
            && $stable(rms_level) && $stable(peak_level))
    else $error("stalled result item changed");

    // Items that do not close a frame carry no metrics.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !metrics_valid |-> rms_level == '0 && peak_level == '0)
    else $error("metrics on a mid-frame item");

    // RMS of 16-bit samples never exceeds 32768.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && metrics_valid |-> rms_level <= 16'd32768)
    else $error("rms level out of range");

    // Come out of reset with no pending result.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind mic_frame_peak_rms_meter mfpr_checker u_mfpr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pcm_sample    (pcm_sample),
    .pcm_valid     (pcm_valid),
    .metrics_valid (metrics_valid),
    .rms_level     (rms_level),
    .peak_level    (peak_level)
);
